### rtl/core/rwhp_pkg.sv
// Package for the RIFF/WAVE header parser: payload structs, status codes,
// chunk tags and the sample format table. No dependencies.
`default_nettype none

package rwhp_pkg;

    localparam int JOB_DEPTH = 2;
    localparam int FMT_COUNT = 19;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_RIFF  = 3'd1;
    localparam logic [2:0] STAT_NOT_WAVE  = 3'd2;
    localparam logic [2:0] STAT_FMT_SHORT = 3'd3;
    localparam logic [2:0] STAT_RATE_MISS = 3'd4;
    localparam logic [2:0] STAT_NO_FORMAT = 3'd5;
    localparam logic [2:0] STAT_TRUNCATED = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_RIFX = 32'h52494658;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [15:0] CODE_PCM   = 16'h0001;
    localparam logic [15:0] CODE_FLOAT = 16'h0003;
    localparam logic [15:0] CODE_ALAW  = 16'h0006;
    localparam logic [15:0] CODE_MULAW = 16'h0007;

    typedef struct packed {
        logic       start_req;
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        big_endian;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [15:0] valid_bits;
        logic [4:0]  sample_format;
        logic [31:0] data_bytes;
    } result_t;

    // Work handed from the byte parser to the format checker.
    typedef struct packed {
        logic        finish;
        logic [2:0]  status;
        logic        big_endian;
        logic [15:0] code;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [31:0] avg_rate;
        logic [15:0] bits;
        logic [31:0] data_bytes;
    } job_t;

    typedef struct packed {
        logic [15:0] code;
        logic [7:0]  width;
        logic [7:0]  phys;
        logic        is_be;
    } fmt_entry_t;

    function automatic fmt_entry_t fmt_entry(input logic [4:0] idx);
        fmt_entry_t e;
        case (idx)
            5'd0:    e = '{CODE_PCM,   8'd8,  8'd8,  1'b0};
            5'd1:    e = '{CODE_PCM,   8'd16, 8'd16, 1'b0};
            5'd2:    e = '{CODE_PCM,   8'd16, 8'd16, 1'b1};
            5'd3:    e = '{CODE_PCM,   8'd24, 8'd32, 1'b0};
            5'd4:    e = '{CODE_PCM,   8'd24, 8'd32, 1'b1};
            5'd5:    e = '{CODE_PCM,   8'd32, 8'd32, 1'b0};
            5'd6:    e = '{CODE_PCM,   8'd32, 8'd32, 1'b1};
            5'd7:    e = '{CODE_PCM,   8'd24, 8'd24, 1'b0};
            5'd8:    e = '{CODE_PCM,   8'd24, 8'd24, 1'b1};
            5'd9:    e = '{CODE_PCM,   8'd20, 8'd24, 1'b0};
            5'd10:   e = '{CODE_PCM,   8'd20, 8'd24, 1'b1};
            5'd11:   e = '{CODE_PCM,   8'd18, 8'd24, 1'b0};
            5'd12:   e = '{CODE_PCM,   8'd18, 8'd24, 1'b1};
            5'd13:   e = '{CODE_FLOAT, 8'd32, 8'd32, 1'b0};
            5'd14:   e = '{CODE_FLOAT, 8'd32, 8'd32, 1'b1};
            5'd15:   e = '{CODE_FLOAT, 8'd64, 8'd64, 1'b0};
            5'd16:   e = '{CODE_FLOAT, 8'd64, 8'd64, 1'b1};
            5'd17:   e = '{CODE_ALAW,  8'd8,  8'd8,  1'b0};
            5'd18:   e = '{CODE_MULAW, 8'd8,  8'd8,  1'b0};
            default: e = '{16'd0, 8'd0, 8'd0, 1'b0};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rwhp_front.sv
// Byte parser: walks RIFF header, form id and subchunks, one byte per cycle
// while accept is high. Depends on rwhp_pkg.
`default_nettype none

module rwhp_front
    import rwhp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t item,
    output logic          job_valid,
    output job_t          job
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_RIFF, PH_FORM, PH_SUBHDR, PH_FMT, PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] field_reg, field_next;
    logic [31:0] skip_reg, skip_next;
    logic        endian_reg, endian_next;
    logic [31:0] tag_reg, tag_next;
    logic [15:0] code_reg, code_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] avg_reg, avg_next;
    logic [15:0] frame_reg, frame_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] prod_reg, prod_next;
    logic [47:0] full_prod;

    assign full_prod = frame_reg * rate_reg;

    function automatic logic [31:0] take_field(input logic [31:0] f, input logic [7:0] b,
                                               input logic [1:0] k, input logic be);
        logic [31:0] base;
        base = (k == 2'd0) ? 32'd0 : f;
        if (be)
            return {base[23:0], b};
        return base | ({24'd0, b} << {k, 3'b000});
    endfunction

    always_comb
    begin
        phase_t     cur;
        logic [4:0] pos;
        logic [7:0] b;
        logic       done;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        field_next  = field_reg;
        skip_next   = skip_reg;
        endian_next = endian_reg;
        tag_next    = tag_reg;
        code_next   = code_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        avg_next    = avg_reg;
        frame_next  = frame_reg;
        bits_next   = bits_reg;
        prod_next   = prod_reg;
        job_valid   = 1'b0;
        job         = '0;
        done        = 1'b0;
        b           = item.data_byte;
        cur         = PH_IDLE;
        pos         = 5'd0;
        if (accept)
        begin
            if (item.start_req)
            begin
                phase_next  = PH_RIFF;
                pos_next    = 5'd0;
                field_next  = '0;
                skip_next   = '0;
                endian_next = 1'b0;
                tag_next    = '0;
                code_next   = '0;
                chan_next   = '0;
                rate_next   = '0;
                avg_next    = '0;
                frame_next  = '0;
                bits_next   = '0;
            end
            cur = phase_next;
            if (cur != PH_IDLE)
            begin
                pos      = pos_next;
                pos_next = pos + 5'd1;
                case (cur)
                    PH_RIFF:
                    begin
                        if (pos < 5'd4)
                            tag_next = {tag_next[23:0], b};
                        if (pos == 5'd7)
                        begin
                            pos_next = 5'd0;
                            if (tag_next == TAG_RIFX)
                            begin
                                endian_next = 1'b1;
                                phase_next  = PH_FORM;
                            end
                            else if (tag_next == TAG_RIFF)
                            begin
                                endian_next = 1'b0;
                                phase_next  = PH_FORM;
                            end
                            else
                            begin
                                done       = 1'b1;
                                job.status = STAT_BAD_RIFF;
                            end
                        end
                    end
                    PH_FORM:
                    begin
                        tag_next = {tag_next[23:0], b};
                        if (pos == 5'd3)
                        begin
                            pos_next = 5'd0;
                            if (tag_next != TAG_WAVE)
                            begin
                                done       = 1'b1;
                                job.status = STAT_NOT_WAVE;
                            end
                            else
                                phase_next = PH_SUBHDR;
                        end
                    end
                    PH_SUBHDR:
                    begin
                        if (pos < 5'd4)
                            tag_next = {tag_next[23:0], b};
                        else
                            field_next = take_field(field_next, b, pos[1:0], endian_next);
                        if (pos == 5'd7)
                        begin
                            pos_next = 5'd0;
                            if (tag_next == TAG_FMT)
                            begin
                                if (field_next < 32'd16)
                                begin
                                    done       = 1'b1;
                                    job.status = STAT_FMT_SHORT;
                                end
                                else
                                begin
                                    skip_next  = field_next - 32'd16;
                                    phase_next = PH_FMT;
                                end
                            end
                            else if (tag_next == TAG_DATA)
                            begin
                                done           = 1'b1;
                                job.finish     = 1'b1;
                                job.code       = code_next;
                                job.channels   = chan_next;
                                job.rate       = rate_next;
                                job.avg_rate   = avg_next;
                                job.bits       = bits_next;
                                job.data_bytes = field_next;
                            end
                            else
                            begin
                                skip_next  = field_next;
                                phase_next = (field_next != 32'd0) ? PH_SKIP : PH_SUBHDR;
                            end
                        end
                    end
                    PH_FMT:
                    begin
                        if ((pos >= 5'd4) && (pos < 5'd12))
                            field_next = take_field(field_next, b, pos[1:0], endian_next);
                        else
                            field_next = take_field(field_next, b, {1'b0, pos[0]},
                                                    endian_next);
                        if (pos == 5'd1)
                            code_next = field_next[15:0];
                        if (pos == 5'd3)
                            chan_next = field_next[15:0];
                        if (pos == 5'd7)
                            rate_next = field_next;
                        if (pos == 5'd11)
                            avg_next = field_next;
                        if (pos == 5'd13)
                            frame_next = field_next[15:0];
                        if (pos == 5'd14)
                            prod_next = full_prod[31:0];
                        if (pos == 5'd15)
                        begin
                            bits_next = field_next[15:0];
                            pos_next  = 5'd0;
                            if (avg_next != prod_reg)
                            begin
                                done       = 1'b1;
                                job.status = STAT_RATE_MISS;
                            end
                            else
                                phase_next = (skip_next != 32'd0) ? PH_SKIP : PH_SUBHDR;
                        end
                    end
                    PH_SKIP:
                    begin
                        pos_next = 5'd0;
                        if (skip_next != 32'd0)
                            skip_next = skip_next - 32'd1;
                        if (skip_next == 32'd0)
                            phase_next = PH_SUBHDR;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
                if (!done && item.end_of_stream)
                begin
                    done       = 1'b1;
                    job.status = STAT_TRUNCATED;
                end
                if (done)
                begin
                    job_valid      = 1'b1;
                    job.big_endian = endian_next;
                    phase_next     = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            field_reg  <= '0;
            skip_reg   <= '0;
            endian_reg <= 1'b0;
            tag_reg    <= '0;
            code_reg   <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            avg_reg    <= '0;
            frame_reg  <= '0;
            bits_reg   <= '0;
            prod_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            field_reg  <= field_next;
            skip_reg   <= skip_next;
            endian_reg <= endian_next;
            tag_reg    <= tag_next;
            code_reg   <= code_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            avg_reg    <= avg_next;
            frame_reg  <= frame_next;
            bits_reg   <= bits_next;
            prod_reg   <= prod_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rwhp_fifo.sv
// Short job queue between the byte parser and the format checker.
// Depends on rwhp_pkg.
`default_nettype none

module rwhp_fifo
    import rwhp_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_data,
    output logic      empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + AW'(1);
            if (do_pop)
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

### rtl/core/rwhp_back.sv
// Format checker: physical width by two bit-serial divides, table match,
// and the result register. Depends on rwhp_pkg.
`default_nettype none

module rwhp_back
    import rwhp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_empty,
    input  wire job_t job_data,
    output logic      job_pop,
    input  wire logic pop,
    output logic      empty,
    output result_t   result
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV1, ST_DIV2, ST_MATCH
    } state_t;

    state_t      state_reg;
    job_t        job_reg;
    result_t     out_reg;
    logic        out_valid_reg;
    logic [31:0] rem_reg, quo_reg, divisor_reg;
    logic [4:0]  cnt_reg;

    logic [32:0] rem_sh, diff;
    logic [31:0] rem_next, quo_next;
    logic        found;
    logic [4:0]  found_idx;

    assign job_pop = (state_reg == ST_IDLE) && !job_empty && !out_valid_reg;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    // One restoring step per cycle.
    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign diff     = rem_sh - {1'b0, divisor_reg};
    assign rem_next = diff[32] ? rem_sh[31:0] : diff[31:0];
    assign quo_next = {quo_reg[30:0], !diff[32]};

    always_comb
    begin
        fmt_entry_t e;
        found     = 1'b0;
        found_idx = '0;
        for (int i = FMT_COUNT - 1; i >= 0; i--)
        begin
            e = fmt_entry(5'(i));
            if ((job_reg.code == e.code) && (job_reg.bits == {8'd0, e.width})
                && (quo_reg == {24'd0, e.phys}) && !(job_reg.big_endian && !e.is_be))
            begin
                found     = 1'b1;
                found_idx = 5'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_pop)
                    begin
                        job_reg <= job_data;
                        if (!job_data.finish)
                        begin
                            out_reg       <= '{job_data.status, job_data.big_endian,
                                               16'd0, 16'd0, 32'd0, 16'd0, 5'd0, 32'd0};
                            out_valid_reg <= 1'b1;
                        end
                        else if ((job_data.channels == 16'd0) || (job_data.rate == 32'd0))
                        begin
                            out_reg       <= '{STAT_NO_FORMAT, job_data.big_endian,
                                               job_data.code, job_data.channels,
                                               job_data.rate, job_data.bits, 5'd0,
                                               job_data.data_bytes};
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            rem_reg     <= '0;
                            quo_reg     <= {job_data.avg_rate[28:0], 3'b000};
                            divisor_reg <= {16'd0, job_data.channels};
                            cnt_reg     <= '0;
                            state_reg   <= ST_DIV1;
                        end
                    end
                end
                ST_DIV1:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    quo_reg <= quo_next;
                    if (cnt_reg == 5'd31)
                    begin
                        rem_reg     <= '0;
                        divisor_reg <= job_reg.rate;
                        state_reg   <= ST_DIV2;
                    end
                    else
                        rem_reg <= rem_next;
                end
                ST_DIV2:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    if (cnt_reg == 5'd31)
                        state_reg <= ST_MATCH;
                end
                ST_MATCH:
                begin
                    out_reg       <= '{found ? STAT_OK : STAT_NO_FORMAT, job_reg.big_endian,
                                       job_reg.code, job_reg.channels, job_reg.rate,
                                       job_reg.bits, found ? found_idx : 5'd0,
                                       job_reg.data_bytes};
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result changed before transfer");
    a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (!out_valid_reg && !job_empty))
        else $error("job taken while result register busy");
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV1) || (state_reg == ST_DIV2)) |-> (divisor_reg != 32'd0))
        else $error("divide by zero in width check");
    a_match_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) |-> ($past(state_reg) == ST_DIV2))
        else $error("table match entered without divide");
`endif

endmodule

`default_nettype wire

### rtl/core/riff_wave_header_parser.sv
// Top level of the RIFF/WAVE header parser: byte parser, job queue, checker.
// Depends on rwhp_pkg, rwhp_front, rwhp_fifo, rwhp_back.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------
//  input    | push / full      | item   (in_item_t, one byte)
//  result   | pop  / empty     | result (result_t)
//
// The parser takes one byte per cycle while the job queue has room.
// A data header ending with a usable fmt chunk goes through the checker's
// two 32-step bit-serial divides (physical width) and one table match;
// every other result goes to the result register as its job is popped.
// Reset clears all control state; no clearing pass is needed.
// full rises only while the job queue holds DEPTH unchecked results.
`default_nettype none

module riff_wave_header_parser
    import rwhp_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    input  wire logic     pop,
    output logic          empty,
    output result_t       result
);

    logic accept;
    logic job_valid, job_empty, job_pop;
    job_t job, job_data;

    // Accept a byte only when the queue can hold any result it triggers.
    assign accept = push && !full;

    rwhp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .job_valid (job_valid),
        .job       (job)
    );

    rwhp_fifo #(.DEPTH(DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data (job),
        .full      (full),
        .pop       (job_pop),
        .pop_data  (job_data),
        .empty     (job_empty)
    );

    rwhp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_data  (job_data),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

### sim/tb_riff_wave_header_parser.sv
// Testbench for riff_wave_header_parser: streams RIFF/WAVE headers byte by byte,
// predicts each parse result in-house and checks the result queue. Needs rwhp_pkg.
`default_nettype none

module tb_riff_wave_header_parser;
    import rwhp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        P_IDLE, P_RIFF, P_FORM, P_SUBHDR, P_FMT, P_SKIP
    } parse_phase_t;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    in_item_t item;
    logic     pop;
    logic     empty;
    result_t  result;

    riff_wave_header_parser DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .pop(pop), .empty(empty), .result(result)
    );

    // Predictor state: a private copy of the parser's registers.
    parse_phase_t pr_phase;
    logic [4:0]   pr_pos;
    logic [31:0]  pr_field;
    logic [31:0]  pr_skip;
    logic         pr_be;
    logic [31:0]  pr_tag;
    logic [15:0]  pr_code;
    logic [15:0]  pr_chan;
    logic [31:0]  pr_rate;
    logic [31:0]  pr_avg;
    logic [15:0]  pr_frame;
    logic [15:0]  pr_bits;

    in_item_t byte_queue[$];
    result_t  expected_results[$];
    int       error_count = 0;
    int       send_idle_pct = 14;
    int       recv_idle_pct = 62;
    bit       stim_done = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("riff_wave_header_parser test failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void parser_clear();
        pr_phase = P_IDLE;
        pr_pos = '0; pr_field = '0; pr_skip = '0; pr_be = 1'b0; pr_tag = '0;
        pr_code = '0; pr_chan = '0; pr_rate = '0; pr_avg = '0;
        pr_frame = '0; pr_bits = '0;
    endfunction

    // Assemble byte k of a multi-byte field in the file's byte order.
    function automatic void gather_field(input logic [7:0] b, input logic [4:0] k);
        if (k == 0)
            pr_field = '0;
        if (pr_be)
            pr_field = {pr_field[23:0], b};
        else
            pr_field = pr_field | (32'(b) << (8 * k[1:0]));
    endfunction

    function automatic result_t make_result(input logic [2:0] st, input bit full_res,
                                            input logic [4:0] sfmt,
                                            input logic [31:0] dbytes);
        result_t r;
        r = '0;
        r.status = st;
        r.big_endian = pr_be;
        if (full_res)
        begin
            r.format_tag = pr_code;
            r.channels = pr_chan;
            r.sample_rate = pr_rate;
            r.valid_bits = pr_bits;
            r.sample_format = sfmt;
            r.data_bytes = dbytes;
        end
        pr_phase = P_IDLE;
        return r;
    endfunction

    // Physical width check and first-match lookup in the format table.
    function automatic result_t match_format(input logic [31:0] dbytes);
        logic [31:0] phys;
        logic [15:0] code;
        logic [7:0]  wid;
        logic [7:0]  pw;
        logic        be;
        if (pr_chan == 0 || pr_rate == 0)
            return make_result(STAT_NO_FORMAT, 1'b1, 5'd0, dbytes);
        phys = (pr_avg << 3) / 32'(pr_chan) / pr_rate;
        for (int i = 0; i < FMT_COUNT; i++)
        begin
            be = 1'b0;
            case (i)
                0, 17, 18: begin wid = 8;  pw = 8;  end
                1, 2:      begin wid = 16; pw = 16; end
                3, 4:      begin wid = 24; pw = 32; end
                5, 6, 13, 14: begin wid = 32; pw = 32; end
                7, 8:      begin wid = 24; pw = 24; end
                9, 10:     begin wid = 20; pw = 24; end
                11, 12:    begin wid = 18; pw = 24; end
                default:   begin wid = 64; pw = 64; end
            endcase
            if (i < 13) code = CODE_PCM;
            else if (i < 17) code = CODE_FLOAT;
            else if (i == 17) code = CODE_ALAW;
            else code = CODE_MULAW;
            if (i inside {2, 4, 6, 8, 10, 12, 14, 16}) be = 1'b1;
            if (pr_code == code && pr_bits == 16'(wid) && phys == 32'(pw) && (!pr_be || be))
                return make_result(STAT_OK, 1'b1, 5'(i), dbytes);
        end
        return make_result(STAT_NO_FORMAT, 1'b1, 5'd0, dbytes);
    endfunction

    // Advance the predictor by one accepted byte; returns 1 with a result.
    function automatic bit parse_byte(input in_item_t it, output result_t r);
        logic [4:0] p;
        logic [7:0] b;
        b = it.data_byte;
        r = '0;
        if (it.start_req)
        begin
            parser_clear();
            pr_phase = P_RIFF;
        end
        if (pr_phase == P_IDLE)
            return 0;
        p = pr_pos;
        pr_pos = pr_pos + 1;
        case (pr_phase)
            P_RIFF:
            begin
                if (p < 4) pr_tag = {pr_tag[23:0], b};
                if (p == 7)
                begin
                    pr_pos = 0;
                    if (pr_tag == TAG_RIFX) pr_be = 1'b1;
                    else if (pr_tag == TAG_RIFF) pr_be = 1'b0;
                    else begin r = make_result(STAT_BAD_RIFF, 0, 0, 0); return 1; end
                    pr_phase = P_FORM;
                end
            end
            P_FORM:
            begin
                pr_tag = {pr_tag[23:0], b};
                if (p == 3)
                begin
                    pr_pos = 0;
                    if (pr_tag != TAG_WAVE)
                    begin
                        r = make_result(STAT_NOT_WAVE, 0, 0, 0);
                        return 1;
                    end
                    pr_phase = P_SUBHDR;
                end
            end
            P_SUBHDR:
            begin
                if (p < 4) pr_tag = {pr_tag[23:0], b};
                else gather_field(b, p - 4);
                if (p == 7)
                begin
                    pr_pos = 0;
                    if (pr_tag == TAG_FMT)
                    begin
                        if (pr_field < 16)
                        begin
                            r = make_result(STAT_FMT_SHORT, 0, 0, 0);
                            return 1;
                        end
                        pr_skip = pr_field - 16;
                        pr_phase = P_FMT;
                    end
                    else if (pr_tag == TAG_DATA)
                    begin
                        r = match_format(pr_field);
                        return 1;
                    end
                    else
                    begin
                        pr_skip = pr_field;
                        pr_phase = (pr_skip != 0) ? P_SKIP : P_SUBHDR;
                    end
                end
            end
            P_FMT:
            begin
                if (p < 2)
                begin
                    gather_field(b, p);
                    if (p == 1) pr_code = pr_field[15:0];
                end
                else if (p < 4)
                begin
                    gather_field(b, p - 2);
                    if (p == 3) pr_chan = pr_field[15:0];
                end
                else if (p < 8)
                begin
                    gather_field(b, p - 4);
                    if (p == 7) pr_rate = pr_field;
                end
                else if (p < 12)
                begin
                    gather_field(b, p - 8);
                    if (p == 11) pr_avg = pr_field;
                end
                else if (p < 14)
                begin
                    gather_field(b, p - 12);
                    if (p == 13) pr_frame = pr_field[15:0];
                end
                else
                begin
                    gather_field(b, p - 14);
                    if (p == 15)
                    begin
                        pr_bits = pr_field[15:0];
                        pr_pos = 0;
                        if (pr_avg != 32'(pr_frame) * pr_rate)
                        begin
                            r = make_result(STAT_RATE_MISS, 0, 0, 0);
                            return 1;
                        end
                        pr_phase = (pr_skip != 0) ? P_SKIP : P_SUBHDR;
                    end
                end
            end
            P_SKIP:
            begin
                pr_pos = 0;
                if (pr_skip > 0) pr_skip--;
                if (pr_skip == 0) pr_phase = P_SUBHDR;
            end
            default:
            begin
                pr_phase = P_IDLE;
                return 0;
            end
        endcase
        if (it.end_of_stream)
        begin
            r = make_result(STAT_TRUNCATED, 0, 0, 0);
            return 1;
        end
        return 0;
    endfunction

    // Stimulus builders: append bytes to the pending queue.
    task automatic put_byte(input logic [7:0] b, input bit first = 0, input bit last = 0);
        in_item_t it;
        it.start_req = first;
        it.data_byte = b;
        it.end_of_stream = last;
        byte_queue.push_back(it);
    endtask

    task automatic put_tag(input logic [31:0] t, input bit first = 0);
        for (int i = 3; i >= 0; i--)
            put_byte(t[8*i +: 8], first && i == 3);
    endtask

    task automatic put_word(input logic [31:0] v, input int n, input bit be);
        for (int i = 0; i < n; i++)
            put_byte(be ? v[8*(n-1-i) +: 8] : v[8*i +: 8]);
    endtask

    // Table entry fields used to build files that match.
    task automatic pick_entry(input int idx, output logic [15:0] code,
                              output logic [15:0] bits, output int pbytes);
        case (idx)
            0, 17, 18: begin bits = 8;  pbytes = 1; end
            1, 2:      begin bits = 16; pbytes = 2; end
            3, 4:      begin bits = 24; pbytes = 4; end
            5, 6, 13, 14: begin bits = 32; pbytes = 4; end
            7, 8:      begin bits = 24; pbytes = 3; end
            9, 10:     begin bits = 20; pbytes = 3; end
            11, 12:    begin bits = 18; pbytes = 3; end
            default:   begin bits = 64; pbytes = 8; end
        endcase
        if (idx < 13) code = CODE_PCM;
        else if (idx < 17) code = CODE_FLOAT;
        else if (idx == 17) code = CODE_ALAW;
        else code = CODE_MULAW;
    endtask

    // One file: mode 0 clean match, 1 random fmt content, 2 no fmt chunk,
    // 3 short fmt, 4 rate mismatch, 5 bad riff, 6 not wave, 7 truncated.
    task automatic put_file(input int mode, input bit be, input int entry);
        logic [15:0] code, bits, chan, frame;
        logic [31:0] rate, avg, fsize;
        int          pbytes, cut, extra, n0;
        n0 = byte_queue.size();
        pick_entry(entry, code, bits, pbytes);
        chan = $urandom_range(1, 8);
        rate = $urandom_range(1, 192000);
        frame = chan * pbytes;
        avg = 32'(frame) * rate;
        if (mode == 1)
        begin
            code = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8));
            bits = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 70));
            chan = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
            rate = $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 4));
            frame = $urandom;
            avg = 32'(frame) * rate;
        end
        if (mode == 4)
            avg = avg ^ (32'd1 << $urandom_range(0, 31));
        if (mode == 5)
            put_tag($urandom_range(0, 1) ? 32'($urandom) : (TAG_RIFF ^ 32'h100), 1);
        else
            put_tag(be ? TAG_RIFX : TAG_RIFF, 1);
        put_word($urandom, 4, be);
        put_tag(mode == 6 ? 32'($urandom) : TAG_WAVE);
        if ($urandom_range(0, 3) == 0)
        begin
            extra = $urandom_range(0, 5);
            put_tag($urandom);
            put_word(extra, 4, be);
            repeat (extra) put_byte($urandom);
        end
        if (mode != 2)
        begin
            fsize = (mode == 3) ? 32'($urandom_range(0, 15)) : 32'(16 + $urandom_range(0, 2) * 2);
            put_tag(TAG_FMT);
            put_word(fsize, 4, be);
            if (mode != 3)
            begin
                put_word(code, 2, be);
                put_word(chan, 2, be);
                put_word(rate, 4, be);
                put_word(avg, 4, be);
                put_word(frame, 2, be);
                put_word(bits, 2, be);
                repeat (fsize - 16) put_byte($urandom);
            end
        end
        put_tag(TAG_DATA);
        put_word($urandom, 4, be);
        if (mode == 7)
        begin
            cut = $urandom_range(n0, byte_queue.size() - 2);
            while (byte_queue.size() > cut + 1)
                void'(byte_queue.pop_back());
            byte_queue[cut].end_of_stream = 1'b1;
        end
    endtask

    // Driver: hand one pending byte per transfer, idle at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                result_t r;
                if (parse_byte(item, r))
                    expected_results.push_back(r);
            end
            if (!(push && full))
            begin
                if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    item <= byte_queue.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                result_t w;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 32'(result.status), 32'd0);
                else
                begin
                    w = expected_results.pop_front();
                    if (result.status != w.status) report_mismatch("status", result.status, w.status);
                    if (result.big_endian != w.big_endian)
                        report_mismatch("big_endian", result.big_endian, w.big_endian);
                    if (result.format_tag != w.format_tag)
                        report_mismatch("format_tag", result.format_tag, w.format_tag);
                    if (result.channels != w.channels)
                        report_mismatch("channels", result.channels, w.channels);
                    if (result.sample_rate != w.sample_rate)
                        report_mismatch("sample_rate", result.sample_rate, w.sample_rate);
                    if (result.valid_bits != w.valid_bits)
                        report_mismatch("valid_bits", result.valid_bits, w.valid_bits);
                    if (result.sample_format != w.sample_format)
                        report_mismatch("sample_format", result.sample_format, w.sample_format);
                    if (result.data_bytes != w.data_bytes)
                        report_mismatch("data_bytes", result.data_bytes, w.data_bytes);
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (byte_queue.size() > 0 || push || expected_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        int bytes_sent;
        int m;
        parser_clear();
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle bytes, every table entry, each error kind, restart.
        put_byte(8'hFF, 0, 1);
        put_byte(8'h00);
        for (int e = 0; e < FMT_COUNT; e++)
            put_file(0, e inside {2, 4, 6, 8, 10, 12, 14, 16}, e);
        for (int md = 1; md <= 7; md++)
            put_file(md, md[0], 1);
        put_tag(TAG_RIFF, 1);
        put_byte(8'h00);
        put_file(0, 0, 5);

        // Three idling regimes over random files.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 14 : (ph == 1 ? 62 : 0);
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1 ? 14 : 0);
            bytes_sent = 0;
            while (bytes_sent < 250)
            begin
                m = $urandom_range(0, 9);
                m = (m < 5) ? 0 : m - 3;
                if ($urandom_range(0, 19) == 0)
                    put_byte($urandom, $urandom_range(0, 1), $urandom_range(0, 1));
                put_file(m, $urandom_range(0, 1), $urandom_range(0, FMT_COUNT - 1));
                bytes_sent += byte_queue.size();
                while (byte_queue.size() > 0)
                    @(posedge clk);
            end
        end
        wait_drained();
        if (error_count == 0)
            $display("riff_wave_header_parser test passed");
        else
            $display("riff_wave_header_parser test failed");
        $finish;
    end

endmodule

`default_nettype wire
